FILE: rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int TASK_SLOTS_DEF  = 5;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 3;
   localparam int DROP_W  = 4;

   typedef enum logic [1:0] {
      ACT_ADD      = 2'd0,
      ACT_START    = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_DISPATCH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_ADD_RUNNING = 2'd1,
      STATUS_TABLE_FULL  = 2'd2,
      STATUS_NOT_STARTED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_FINISH,
      ST_POP
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] ready_slot;
      logic              slot_valid;
      status_type        status;
      logic [DROP_W-1:0] dropped_count;
      logic              last_result;
   } rsp_word_type;

endpackage

FILE: rtl/ptts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ptts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: walks the task table on a tick, drains the ready ring on a
// dispatch, and produces one result word at a time.
// ----------------------------------------------------------------------------
module ptts_ctrl #(
   parameter int TASK_SLOTS  = ptts_pkg::TASK_SLOTS_DEF,
   parameter int QUEUE_DEPTH = ptts_pkg::QUEUE_DEPTH_DEF,
   parameter int SLOT_AW     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1,
   parameter int RING_AW     = $clog2(QUEUE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [1:0]                    req_action,
   input  logic [ptts_pkg::TIME_W-1:0]   req_start_delay,
   input  logic [ptts_pkg::TIME_W-1:0]   req_repeat_period,
   output logic                          req_stall,
   input  logic                          out_free,
   output logic                          out_load,
   output ptts_pkg::rsp_word_type        out_word,
   output logic                          tbl_wr_en,
   output logic [SLOT_AW-1:0]            tbl_wr_addr,
   output logic [2*ptts_pkg::TIME_W-1:0] tbl_wr_data,
   output logic                          tbl_rd_en,
   output logic [SLOT_AW-1:0]            tbl_rd_addr,
   input  logic [2*ptts_pkg::TIME_W-1:0] tbl_rd_data,
   output logic                          ring_wr_en,
   output logic [RING_AW-1:0]            ring_wr_addr,
   output logic [ptts_pkg::SLOT_W-1:0]   ring_wr_data,
   output logic                          ring_rd_en,
   output logic [RING_AW-1:0]            ring_rd_addr,
   input  logic [ptts_pkg::SLOT_W-1:0]   ring_rd_data
);

   localparam int USED_W = $clog2(TASK_SLOTS + 1);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TW     = ptts_pkg::TIME_W;

   ptts_pkg::state_type             state_ff, state_in;
   ptts_pkg::action_type            action_ff;
   logic [TW-1:0]                   delay_ff, period_ff;
   logic                            running_ff, running_in;
   logic [USED_W-1:0]               used_ff, used_in;
   logic [SLOT_AW-1:0]              idx_ff, idx_in;
   logic [RING_AW-1:0]              head_ff, head_in, tail_ff, tail_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic [ptts_pkg::DROP_W-1:0]     dropped_ff, dropped_in;

   logic                            accept;
   logic                            last_slot;
   logic                            table_full;
   logic [TW-1:0]                   cd_cur, cd_dec, cd_new, reload;
   logic                            fire;
   logic [RING_AW-1:0]              head_next, tail_next;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ptts_pkg::ST_IDLE);
   assign last_slot  = ((USED_W'(idx_ff) + USED_W'(1)) == used_ff);
   assign table_full = (used_ff == USED_W'(TASK_SLOTS));

   assign cd_cur = tbl_rd_data[TW-1:0];
   assign reload = tbl_rd_data[2*TW-1:TW];
   assign cd_dec = (cd_cur != '0) ? cd_cur - TW'(1) : '0;
   assign fire   = (cd_dec == '0);
   assign cd_new = fire ? reload : cd_dec;

   assign head_next = (head_ff == RING_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + RING_AW'(1);
   assign tail_next = (tail_ff == RING_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + RING_AW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = ptts_pkg::ST_EXEC;
            end
         end
         ptts_pkg::ST_EXEC: begin
            if (running_ff && action_ff == ptts_pkg::ACT_TICK) begin
               state_in = (used_ff == '0) ? ptts_pkg::ST_FINISH : ptts_pkg::ST_TICK;
            end else if (running_ff && action_ff == ptts_pkg::ACT_DISPATCH
                         && fill_ff != '0) begin
               state_in = ptts_pkg::ST_POP;
            end else if (out_free) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         ptts_pkg::ST_TICK: begin
            if (last_slot) begin
               state_in = ptts_pkg::ST_FINISH;
            end
         end
         ptts_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         ptts_pkg::ST_POP: begin
            if (out_free && fill_ff == FILL_W'(1)) begin
               state_in = ptts_pkg::ST_IDLE;
            end
         end
         default: state_in = ptts_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      running_in   = running_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      out_load     = 1'b0;
      out_word     = '{ready_slot: '0, slot_valid: 1'b0, status: ptts_pkg::STATUS_OK,
                       dropped_count: '0, last_result: 1'b1};
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = idx_ff;
      tbl_wr_data  = {reload, cd_new};
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = idx_ff;
      ring_wr_en   = 1'b0;
      ring_wr_addr = tail_ff;
      ring_wr_data = ptts_pkg::SLOT_W'(idx_ff);
      ring_rd_en   = 1'b0;
      ring_rd_addr = head_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               dropped_in = '0;
            end
         end
         ptts_pkg::ST_EXEC: begin
            case (action_ff)
               ptts_pkg::ACT_ADD: begin
                  out_load = out_free;
                  if (running_ff) begin
                     out_word.status = ptts_pkg::STATUS_ADD_RUNNING;
                  end else if (table_full) begin
                     out_word.status = ptts_pkg::STATUS_TABLE_FULL;
                  end else begin
                     out_word.slot_valid = 1'b1;
                     out_word.ready_slot = ptts_pkg::SLOT_W'(used_ff);
                     tbl_wr_en   = out_free;
                     tbl_wr_addr = SLOT_AW'(used_ff);
                     tbl_wr_data = {period_ff, delay_ff};
                     if (out_free) begin
                        used_in = used_ff + USED_W'(1);
                     end
                  end
               end
               ptts_pkg::ACT_START: begin
                  out_load = out_free;
                  if (out_free) begin
                     running_in = 1'b1;
                  end
               end
               ptts_pkg::ACT_TICK: begin
                  if (!running_ff) begin
                     out_load        = out_free;
                     out_word.status = ptts_pkg::STATUS_NOT_STARTED;
                  end else begin
                     tbl_rd_en   = (used_ff != '0);
                     tbl_rd_addr = '0;
                  end
               end
               ptts_pkg::ACT_DISPATCH: begin
                  if (!running_ff) begin
                     out_load        = out_free;
                     out_word.status = ptts_pkg::STATUS_NOT_STARTED;
                  end else if (fill_ff == '0) begin
                     out_load = out_free;
                  end else begin
                     ring_rd_en = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ptts_pkg::ST_TICK: begin
            tbl_wr_en = 1'b1;
            if (fire) begin
               if (fill_ff < FILL_W'(QUEUE_DEPTH)) begin
                  ring_wr_en = 1'b1;
                  tail_in    = tail_next;
                  fill_in    = fill_ff + FILL_W'(1);
               end else begin
                  dropped_in = dropped_ff + ptts_pkg::DROP_W'(1);
               end
            end
            if (!last_slot) begin
               tbl_rd_en   = 1'b1;
               tbl_rd_addr = idx_ff + SLOT_AW'(1);
               idx_in      = idx_ff + SLOT_AW'(1);
            end
         end
         ptts_pkg::ST_FINISH: begin
            out_load               = out_free;
            out_word.dropped_count = dropped_ff;
         end
         ptts_pkg::ST_POP: begin
            out_load               = out_free;
            out_word.slot_valid    = 1'b1;
            out_word.ready_slot    = ring_rd_data;
            out_word.last_result   = (fill_ff == FILL_W'(1));
            if (out_free) begin
               head_in = head_next;
               fill_in = fill_ff - FILL_W'(1);
               if (fill_ff != FILL_W'(1)) begin
                  ring_rd_en   = 1'b1;
                  ring_rd_addr = head_next;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ptts_pkg::ST_IDLE;
         running_ff <= 1'b0;
         used_ff    <= '0;
         idx_ff     <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         fill_ff    <= '0;
         dropped_ff <= '0;
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
         used_ff    <= used_in;
         idx_ff     <= idx_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= ptts_pkg::action_type'(req_action);
         delay_ff  <= req_start_delay;
         period_ff <= req_repeat_period;
      end
   end

endmodule

FILE: rtl/periodic_task_tick_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Periodic task table with tick countdowns and a ring of ready slot numbers.
//
//   channel | dir | handshake           | words
//   req     | in  | req_valid/req_stall | action, start_delay, repeat_period
//   rsp     | out | rsp_valid/rsp_stall | ready_slot, slot_valid, status,
//           |     |                     | dropped_count, last_result
//
// Add, start and refused items: a single result word, loaded in EXEC.
// Tick: one table RAM read-modify-write per cycle over the used slots.
// Dispatch: ring read in EXEC, then one slot per cycle while not stalled.
// Reset clears the control state only; RAM contents need no clearing pass.
// rsp_stall holds the sequencer; req_stall is high while an item is in work.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top #(
   parameter int TASK_SLOTS  = ptts_pkg::TASK_SLOTS_DEF,
   parameter int QUEUE_DEPTH = ptts_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_action,
   input  logic [ptts_pkg::TIME_W-1:0] req_start_delay,
   input  logic [ptts_pkg::TIME_W-1:0] req_repeat_period,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ptts_pkg::SLOT_W-1:0] rsp_ready_slot,
   output logic                        rsp_slot_valid,
   output logic [1:0]                  rsp_status,
   output logic [ptts_pkg::DROP_W-1:0] rsp_dropped_count,
   output logic                        rsp_last_result
);

   localparam int SLOT_AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int RING_AW = $clog2(QUEUE_DEPTH);
   localparam int TBL_W   = 2 * ptts_pkg::TIME_W;

   logic                        out_free, out_load;
   ptts_pkg::rsp_word_type      out_word;
   ptts_pkg::rsp_word_type      rsp_word_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        tbl_wr_en, tbl_rd_en;
   logic [SLOT_AW-1:0]          tbl_wr_addr, tbl_rd_addr;
   logic [TBL_W-1:0]            tbl_wr_data, tbl_rd_data;
   logic                        ring_wr_en, ring_rd_en;
   logic [RING_AW-1:0]          ring_wr_addr, ring_rd_addr;
   logic [ptts_pkg::SLOT_W-1:0] ring_wr_data, ring_rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   ptts_ctrl #(
      .TASK_SLOTS  (TASK_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SLOT_AW     (SLOT_AW),
      .RING_AW     (RING_AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_action        (req_action),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .req_stall         (req_stall),
      .out_free          (out_free),
      .out_load          (out_load),
      .out_word          (out_word),
      .tbl_wr_en         (tbl_wr_en),
      .tbl_wr_addr       (tbl_wr_addr),
      .tbl_wr_data       (tbl_wr_data),
      .tbl_rd_en         (tbl_rd_en),
      .tbl_rd_addr       (tbl_rd_addr),
      .tbl_rd_data       (tbl_rd_data),
      .ring_wr_en        (ring_wr_en),
      .ring_wr_addr      (ring_wr_addr),
      .ring_wr_data      (ring_wr_data),
      .ring_rd_en        (ring_rd_en),
      .ring_rd_addr      (ring_rd_addr),
      .ring_rd_data      (ring_rd_data)
   );

   ptts_ram #(
      .WIDTH (TBL_W),
      .DEPTH (TASK_SLOTS),
      .AW    (SLOT_AW)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   ptts_ram #(
      .WIDTH (ptts_pkg::SLOT_W),
      .DEPTH (QUEUE_DEPTH),
      .AW    (RING_AW)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (ring_rd_en),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_word_ff <= out_word;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ready_slot    = rsp_word_ff.ready_slot;
   assign rsp_slot_valid    = rsp_word_ff.slot_valid;
   assign rsp_status        = rsp_word_ff.status;
   assign rsp_dropped_count = rsp_word_ff.dropped_count;
   assign rsp_last_result   = rsp_word_ff.last_result;

endmodule

FILE: rtl/ptts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the scheduler's result words.
// ----------------------------------------------------------------------------
module ptts_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ptts_pkg::SLOT_W-1:0] rsp_ready_slot,
   input logic                        rsp_slot_valid,
   input logic [1:0]                  rsp_status,
   input logic [ptts_pkg::DROP_W-1:0] rsp_dropped_count,
   input logic                        rsp_last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ready_slot)
         && $stable(rsp_slot_valid) && $stable(rsp_status)
         && $stable(rsp_dropped_count) && $stable(rsp_last_result))
      else $error("result word changed while stalled");

   a_slot_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_valid |-> rsp_status == ptts_pkg::STATUS_OK
         && rsp_dropped_count == '0)
      else $error("slot word with error status or drops");

   a_no_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_valid |-> rsp_ready_slot == '0 && rsp_last_result)
      else $error("slotless word not single and zeroed");

   a_drop_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped_count != '0 |-> rsp_status == ptts_pkg::STATUS_OK)
      else $error("drops reported with error status");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ptts_pkg::STATUS_OK |-> rsp_last_result
         && !rsp_slot_valid)
      else $error("error word not final");

endmodule

bind periodic_task_tick_scheduler_top ptts_checker u_ptts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_ready_slot    (rsp_ready_slot),
   .rsp_slot_valid    (rsp_slot_valid),
   .rsp_status        (rsp_status),
   .rsp_dropped_count (rsp_dropped_count),
   .rsp_last_result   (rsp_last_result)
);

FILE: verif/periodic_task_tick_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler testbench
// Drives add, start, tick and dispatch words into the scheduler and checks
// every result word against a cycle-free model of the task table and ring.
// A directed table covers refusals, the extremes and ring overflow; a random
// tail mixes ticks and dispatches, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_SLOTS   = ptts_pkg::TASK_SLOTS_DEF;
   localparam int RING_DEPTH  = ptts_pkg::QUEUE_DEPTH_DEF;
   localparam int RAND_WORDS  = 176;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PLAN_ROWS   = 24;

   typedef struct {
      ptts_pkg::action_type act;
      logic [31:0]          delay;
      logic [31:0]          period;
      bit                   typed;
      logic [2:0]           w_slot;
      bit                   w_valid;
      ptts_pkg::status_type w_status;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_NOT_STARTED},
      '{ptts_pkg::ACT_DISPATCH, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_NOT_STARTED},
      '{ptts_pkg::ACT_ADD, 32'd0, 32'd0, 1'b1, 3'd0, 1'b1, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd1, 1'b1, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'd1, 32'd2, 1'b1, 3'd2, 1'b1, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'd2, 32'd3, 1'b1, 3'd3, 1'b1, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'd3, 32'd0, 1'b1, 3'd4, 1'b1, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_TABLE_FULL},
      '{ptts_pkg::ACT_START, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_ADD, 32'd5, 32'd10, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_ADD_RUNNING},
      '{ptts_pkg::ACT_START, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_DISPATCH, 32'd0, 32'd0, 1'b1, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_DISPATCH, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_DISPATCH, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_TICK, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK},
      '{ptts_pkg::ACT_DISPATCH, 32'd0, 32'd0, 1'b0, 3'd0, 1'b0, ptts_pkg::STATUS_OK}
   };

   logic                          clock             = 1'b0;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_action        = ptts_pkg::ACT_ADD;
   logic [ptts_pkg::TIME_W-1:0]   req_start_delay   = '0;
   logic [ptts_pkg::TIME_W-1:0]   req_repeat_period = '0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic [ptts_pkg::SLOT_W-1:0]   rsp_ready_slot;
   logic                          rsp_slot_valid;
   logic [1:0]                    rsp_status;
   logic [ptts_pkg::DROP_W-1:0]   rsp_dropped_count;
   logic                          rsp_last_result;

   // scheduler state as the model sees it
   bit                            sched_running;
   int                            sched_used;
   logic [31:0]                   sched_count  [NUM_SLOTS];
   logic [31:0]                   sched_reload [NUM_SLOTS];
   logic [2:0]                    ready_ring   [RING_DEPTH];
   int                            ring_head;
   int                            ring_tail;
   int                            ring_fill;

   ptts_pkg::rsp_word_type        awaited_words [$];
   ptts_pkg::rsp_word_type        want_word;
   int                            mismatches = 0;
   int                            cycle_count = 0;
   bit                            calm = 1'b0;

   periodic_task_tick_scheduler_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ready_slot    (rsp_ready_slot),
      .rsp_slot_valid    (rsp_slot_valid),
      .rsp_status        (rsp_status),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
               field, got, want, cycle_count);
      mismatches++;
   endtask

   // applies one accepted word to the model, queues the result words it causes
   function automatic void step_scheduler(ptts_pkg::action_type act, logic [31:0] delay,
                                          logic [31:0] period);
      ptts_pkg::rsp_word_type w;
      int                     lost;
      w             = '0;
      w.status      = ptts_pkg::STATUS_OK;
      w.last_result = 1'b1;
      lost          = 0;
      case (act)
         ptts_pkg::ACT_ADD: begin
            if (sched_running) begin
               w.status = ptts_pkg::STATUS_ADD_RUNNING;
            end else if (sched_used >= NUM_SLOTS) begin
               w.status = ptts_pkg::STATUS_TABLE_FULL;
            end else begin
               sched_count[sched_used]  = delay;
               sched_reload[sched_used] = period;
               w.ready_slot = sched_used[2:0];
               w.slot_valid = 1'b1;
               sched_used++;
            end
            awaited_words.push_back(w);
         end
         ptts_pkg::ACT_START: begin
            sched_running = 1'b1;
            awaited_words.push_back(w);
         end
         default: begin
            if (!sched_running) begin
               w.status = ptts_pkg::STATUS_NOT_STARTED;
               awaited_words.push_back(w);
            end else if (act == ptts_pkg::ACT_TICK) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (i < sched_used) begin
                     if (sched_count[i] != 0) sched_count[i]--;
                     if (sched_count[i] == 0) begin
                        if (ring_fill < RING_DEPTH) begin
                           ready_ring[ring_tail] = i[2:0];
                           ring_tail = (ring_tail + 1 == RING_DEPTH) ? 0 : ring_tail + 1;
                           ring_fill++;
                        end else begin
                           lost++;
                        end
                        sched_count[i] = sched_reload[i];
                     end
                  end
               end
               w.dropped_count = lost[ptts_pkg::DROP_W-1:0];
               awaited_words.push_back(w);
            end else if (ring_fill == 0) begin
               awaited_words.push_back(w);
            end else begin
               while (ring_fill > 0) begin
                  w.ready_slot  = ready_ring[ring_head];
                  w.slot_valid  = 1'b1;
                  ring_head     = (ring_head + 1 == RING_DEPTH) ? 0 : ring_head + 1;
                  ring_fill--;
                  w.last_result = (ring_fill == 0);
                  awaited_words.push_back(w);
               end
            end
         end
      endcase
   endfunction

   // called in the time step of a rising edge; returns at the accepting edge
   task automatic send_word(ptts_pkg::action_type act, logic [31:0] delay,
                            logic [31:0] period);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_start_delay   <= delay;
      req_repeat_period <= period;
      do @(posedge clock); while (req_stall);
      step_scheduler(act, delay, period);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_words.size() == 0) begin
            report_mismatch("unexpected word, slot", rsp_ready_slot, 0);
         end else begin
            want_word = awaited_words.pop_front();
            if (rsp_ready_slot !== want_word.ready_slot)
               report_mismatch("ready_slot", rsp_ready_slot, want_word.ready_slot);
            if (rsp_slot_valid !== want_word.slot_valid)
               report_mismatch("slot_valid", rsp_slot_valid, want_word.slot_valid);
            if (rsp_status !== want_word.status)
               report_mismatch("status", rsp_status, want_word.status);
            if (rsp_dropped_count !== want_word.dropped_count)
               report_mismatch("dropped_count", rsp_dropped_count,
                               want_word.dropped_count);
            if (rsp_last_result !== want_word.last_result)
               report_mismatch("last_result", rsp_last_result, want_word.last_result);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", awaited_words.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      ptts_pkg::action_type   act;
      logic [31:0]            delay;
      logic [31:0]            period;
      ptts_pkg::rsp_word_type typed_w;
      int                     pick;
      int                     burst;
      int                     sent;

      sched_running = 1'b0;
      sched_used    = 0;
      ring_head     = 0;
      ring_tail     = 0;
      ring_fill     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         send_word(plan[r].act, plan[r].delay, plan[r].period);
         if (plan[r].typed) begin
            typed_w               = '0;
            typed_w.ready_slot    = plan[r].w_slot;
            typed_w.slot_valid    = plan[r].w_valid;
            typed_w.status        = plan[r].w_status;
            typed_w.last_result   = 1'b1;
            awaited_words[awaited_words.size() - 1] = typed_w;
         end
      end

      sent = 0;
      while (sent < RAND_WORDS) begin
         calm  = (sent >= 60 && sent < 110);
         pick  = $urandom_range(0, 99);
         delay = $urandom;
         period = $urandom;
         burst = 1;
         if (pick < 8) begin
            act = ptts_pkg::ACT_ADD;
         end else if (pick < 12) begin
            act = ptts_pkg::ACT_START;
         end else if (pick < 35) begin
            act = ptts_pkg::ACT_DISPATCH;
         end else begin
            act = ptts_pkg::ACT_TICK;
            // occasional tick runs to overflow the ring
            if ($urandom_range(0, 9) == 0) burst = $urandom_range(4, 8);
         end
         repeat (burst) begin
            send_word(act, delay, period);
            sent++;
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (awaited_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ptts_pkg.sv
rtl/ptts_ram.sv
rtl/ptts_ctrl.sv
rtl/periodic_task_tick_scheduler_top.sv
rtl/ptts_checker.sv
verif/periodic_task_tick_scheduler_tb.sv
